>>> rtl/analog_stick_to_quadrature_direction_top_macros.svh
// Assertion macros shared by the stick converter RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef ANALOG_STICK_TO_QUADRATURE_DIRECTION_TOP_MACROS_SVH
`define ANALOG_STICK_TO_QUADRATURE_DIRECTION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AQD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aqd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aqd assertion failed");

`endif

>>> rtl/aqd_pkg.sv
// Shared constants, codes and types for the stick to quadrature converter.
// No dependencies.
package aqd_pkg;

  localparam int STICK_PORTS = 2;
  localparam int MAX_BUTTONS = 16;

  localparam int AXIS_W     = 16;
  localparam int BTN_W      = 16;
  localparam int DIR_W      = 10;
  localparam int CNT_W      = 2;
  localparam int NUM_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam int BTN_CAP = (MAX_BUTTONS < BTN_W) ? MAX_BUTTONS : BTN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_STICK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTONS_P0  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTONS_P1  = 2'd2;

  localparam logic [CNT_W-1:0] STICK_COUNT_RST = 2'd0;
  localparam logic [NUM_W-1:0] BUTTONS_RST     = 5'd16;

  localparam logic signed [AXIS_W-1:0] LOW_SEEN_RST  = 16'sh7FFF;
  localparam logic signed [AXIS_W-1:0] HIGH_SEEN_RST = 16'sh8000;

  // ceil(2^17 / 3): floor(span / 3) is exact for every 16-bit span.
  localparam logic [15:0] THIRD_RECIP = 16'd43691;
  localparam int          THIRD_SHIFT = 17;

  typedef logic [1:0] aqd_cls_t;
  localparam aqd_cls_t CLS_LOW  = 2'd0;
  localparam aqd_cls_t CLS_MID  = 2'd1;
  localparam aqd_cls_t CLS_HIGH = 2'd2;

  localparam int DIR_BOT_BIT   = 0;
  localparam int DIR_RIGHT_BIT = 1;
  localparam int DIR_TOP_BIT   = 8;
  localparam int DIR_LEFT_BIT  = 9;

  typedef struct packed {
    logic upd;
    logic port;
  } aqd_axis_ctl_t;

endpackage

>>> rtl/aqd_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on aqd_pkg for field widths.
interface aqd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                port;
  logic signed [aqd_pkg::AXIS_W-1:0]   x_sample;
  logic signed [aqd_pkg::AXIS_W-1:0]   y_sample;
  logic        [aqd_pkg::BTN_W-1:0]    raw_buttons;

  modport source (output valid, port, x_sample, y_sample, raw_buttons, input ready);
  modport sink   (input valid, port, x_sample, y_sample, raw_buttons, output ready);
endinterface

interface aqd_out_if;
  logic                             valid;
  logic                             ready;
  logic [aqd_pkg::DIR_W-1:0]        direction_word;
  logic [aqd_pkg::BTN_W-1:0]        button_bits;

  modport source (output valid, direction_word, button_bits, input ready);
  modport sink   (input valid, direction_word, button_bits, output ready);
endinterface

interface aqd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [aqd_pkg::CFG_IDX_W-1:0]      index;
  logic [aqd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/aqd_axis.sv
// One axis: per-port tracked minimum and maximum, and the thirds classifier.
// Depends on aqd_pkg.
module aqd_axis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aqd_pkg::aqd_axis_ctl_t              ctl,
  input  logic signed [aqd_pkg::AXIS_W-1:0]   sample,
  output aqd_pkg::aqd_cls_t                   cls
);
  import aqd_pkg::*;

  logic signed [AXIS_W-1:0] lo_r [STICK_PORTS];
  logic signed [AXIS_W-1:0] hi_r [STICK_PORTS];

  logic signed [AXIS_W-1:0] lo_old, hi_old, lo_nxt, hi_nxt;
  logic        [AXIS_W:0]   diff;
  logic        [15:0]       span;
  logic        [31:0]       prod;
  logic        [14:0]       q;
  logic        [15:0]       three_q;
  logic        [15:0]       rem;
  logic        [15:0]       off2;
  logic signed [17:0]       lo_ext, s_ext, b1, b2;

  always_comb begin
    lo_old  = lo_r[ctl.port];
    hi_old  = hi_r[ctl.port];
    lo_nxt  = (sample < lo_old) ? sample : lo_old;
    hi_nxt  = (sample > hi_old) ? sample : hi_old;
    diff    = {hi_nxt[AXIS_W-1], hi_nxt} - {lo_nxt[AXIS_W-1], lo_nxt};
    span    = diff[15:0];
    prod    = 32'(span) * 32'(THIRD_RECIP);
    q       = prod[THIRD_SHIFT +: 15];
    three_q = {q, 1'b0} + {1'b0, q};
    rem     = span - three_q;
    off2    = {q, 1'b0} + {15'd0, (rem[1:0] == 2'd2)};
    lo_ext  = {{2{lo_nxt[AXIS_W-1]}}, lo_nxt};
    s_ext   = {{2{sample[AXIS_W-1]}}, sample};
    b1      = lo_ext + $signed({3'b000, q});
    b2      = lo_ext + $signed({2'b00, off2});
    if (s_ext < b1) begin
      cls = CLS_LOW;
    end else if (s_ext > b2) begin
      cls = CLS_HIGH;
    end else begin
      cls = CLS_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STICK_PORTS; i++) begin
        lo_r[i] <= LOW_SEEN_RST;
        hi_r[i] <= HIGH_SEEN_RST;
      end
    end else if (ctl.upd) begin
      lo_r[ctl.port] <= lo_nxt;
      hi_r[ctl.port] <= hi_nxt;
    end
  end

endmodule

>>> rtl/analog_stick_to_quadrature_direction_top.sv
// Top level of the analog stick to quadrature direction converter.
// Depends on aqd_pkg, the channel interfaces, aqd_axis and the macros header.
//
// One sample is taken every clock cycle unless a stalled output holds both the
// input register and the result register full. Each result passes through the
// input register and then the result register. Both axis calibration units update
// their per-port limits in the same cycle that classifies a sample, so consecutive
// samples for one port see each other's widening without extra delay. The limits
// come out of reset ready for use. Register writes are taken at any time, one per
// cycle, and should be made while no sample is in flight.
`include "analog_stick_to_quadrature_direction_top_macros.svh"

module analog_stick_to_quadrature_direction_top (
  input  logic     clk,
  input  logic     rst_n,
  aqd_in_if.sink   in_bus,
  aqd_out_if.source out_bus,
  aqd_cfg_if.sink  cfg_bus
);
  import aqd_pkg::*;

  logic [CNT_W-1:0] stick_count_r;
  logic [NUM_W-1:0] btn0_r, btn1_r;

  logic                     in_valid_r;
  logic                     in_port_r;
  logic signed [AXIS_W-1:0] in_x_r, in_y_r;
  logic [BTN_W-1:0]         in_btn_r;

  logic             out_valid_r;
  logic [DIR_W-1:0] out_dir_r;
  logic [BTN_W-1:0] out_btn_r;

  logic             advance, present;
  aqd_axis_ctl_t    axis_ctl;
  aqd_cls_t         cx, cy;
  logic             left, right, top, bot;
  logic [DIR_W-1:0] dir_nxt;
  logic [NUM_W-1:0] num;
  logic [BTN_W-1:0] mask;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_count_r <= STICK_COUNT_RST;
      btn0_r        <= BUTTONS_RST;
      btn1_r        <= BUTTONS_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_STICK_COUNT: stick_count_r <= cfg_bus.data[CNT_W-1:0];
        CFG_BUTTONS_P0:  btn0_r        <= cfg_bus.data;
        CFG_BUTTONS_P1:  btn1_r        <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_port_r <= in_bus.port;
      in_x_r    <= in_bus.x_sample;
      in_y_r    <= in_bus.y_sample;
      in_btn_r  <= in_bus.raw_buttons;
    end
  end

  assign present = ({1'b0, in_port_r} < stick_count_r) && (32'(in_port_r) < STICK_PORTS);

  assign axis_ctl.upd  = in_valid_r && advance && present;
  assign axis_ctl.port = in_port_r;

  aqd_axis u_axis_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (axis_ctl),
    .sample (in_x_r),
    .cls    (cx)
  );

  aqd_axis u_axis_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (axis_ctl),
    .sample (in_y_r),
    .cls    (cy)
  );

  always_comb begin
    left  = (cx == CLS_LOW);
    right = (cx == CLS_HIGH);
    top   = (cy == CLS_LOW) ^ left;
    bot   = (cy == CLS_HIGH) ^ right;
    dir_nxt                = '0;
    dir_nxt[DIR_BOT_BIT]   = bot;
    dir_nxt[DIR_RIGHT_BIT] = right;
    dir_nxt[DIR_TOP_BIT]   = top;
    dir_nxt[DIR_LEFT_BIT]  = left;
    num = in_port_r ? btn1_r : btn0_r;
    for (int i = 0; i < BTN_W; i++) begin
      mask[i] = (32'(num) > i) && (i < BTN_CAP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_dir_r <= present ? dir_nxt : '0;
      out_btn_r <= present ? (in_btn_r & mask) : '0;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.direction_word = out_dir_r;
  assign out_bus.button_bits    = out_btn_r;

  `AQD_ASSERT_NEXT(a_absent_gives_zero, clk, rst_n, advance && in_valid_r && !present,
                   out_dir_r == '0 && out_btn_r == '0)
  `AQD_ASSERT_NOW(a_no_left_and_right, clk, rst_n, out_bus.valid,
                  !(out_bus.direction_word[DIR_LEFT_BIT] &&
                    out_bus.direction_word[DIR_RIGHT_BIT]))
  `AQD_ASSERT_NOW(a_unused_dir_bits, clk, rst_n, out_bus.valid,
                  out_bus.direction_word[7:2] == 6'd0)
  `AQD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_bus.ready,
                  in_valid_r && out_valid_r && !out_bus.ready)
  `AQD_ASSERT_NOW(a_update_only_on_transfer, clk, rst_n, axis_ctl.upd,
                  in_valid_r && (!out_valid_r || out_bus.ready))

endmodule
